[rtl/tlfk_pkg.sv]
// Package of the two-link arm forward kinematics block: payload types, widths,
// CORDIC constants and the small arithmetic helpers shared by the RTL files.
// Depends on nothing.
`default_nettype none

package tlfk_pkg;

  // Angle and trig formats
  localparam int unsigned ANGLE_BITS         = 16;
  localparam int unsigned TRIG_FRACTION_BITS = 15;
  localparam int unsigned TrigW              = TRIG_FRACTION_BITS + 1;

  // CORDIC datapath: 32-bit turn units, 30 fraction bits on x and y
  localparam int unsigned CordicSteps = 28;
  localparam int unsigned CordicFrac  = 30;
  localparam int unsigned TurnW       = 32;
  localparam int unsigned ZW          = 32;
  localparam int unsigned CW          = 33;
  localparam int unsigned TrigShift   = CordicFrac - TRIG_FRACTION_BITS;

  localparam logic signed [CW-1:0] CordicGain = CW'(652032874);
  localparam logic signed [CW-1:0] TrigRound  = CW'(64'd1 << (TrigShift - 1));
  localparam logic signed [CW-1:0] TrigHiWide = CW'((64'd1 << TRIG_FRACTION_BITS) - 1);
  localparam logic signed [CW-1:0] TrigLoWide = -CW'(64'd1 << TRIG_FRACTION_BITS);

  localparam logic signed [ZW-1:0] AtanTurns [CordicSteps] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5
  };

  // Configuration registers
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned BaseW    = 10;
  localparam int unsigned LenW     = 8;

  localparam logic [CfgIdxW-1:0] CfgBaseX   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBaseY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFirstL  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSecondL = 2'd3;

  localparam logic [BaseW-1:0] BaseXReset   = 10'd400;
  localparam logic [BaseW-1:0] BaseYReset   = 10'd300;
  localparam logic [LenW-1:0]  FirstLReset  = 8'd100;
  localparam logic [LenW-1:0]  SecondLReset = 8'd80;

  // Position arithmetic
  localparam int unsigned ProdW  = LenW + 1 + TrigW;
  localparam int unsigned DispW  = ProdW - TRIG_FRACTION_BITS;
  localparam int unsigned PosW   = 13;
  localparam int unsigned CoordW = 12;
  localparam logic signed [PosW-1:0] CoordMin = -13'sd512;
  localparam logic signed [PosW-1:0] CoordMax = 13'sd1535;

  // Pipeline: input, CORDIC steps, trig post, multiply, output
  localparam int unsigned NumStages = CordicSteps + 4;
  localparam int unsigned StTrig    = CordicSteps + 1;
  localparam int unsigned StMul     = CordicSteps + 2;
  localparam int unsigned StOut     = CordicSteps + 3;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] shoulder_angle;
    logic [ANGLE_BITS-1:0] elbow_angle;
  } fk_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] elbow_x;
    logic signed [CoordW-1:0] elbow_y;
    logic signed [CoordW-1:0] tip_x;
    logic signed [CoordW-1:0] tip_y;
  } fk_out_t;

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } trig_t;

  // Round half up to the trig format and clamp to its range
  function automatic logic signed [TrigW-1:0] to_trig(logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [TrigW-1:0] res;
    r = (v + TrigRound) >>> TrigShift;
    if (r > TrigHiWide) begin
      res = TrigHiWide[TrigW-1:0];
    end else if (r < TrigLoWide) begin
      res = TrigLoWide[TrigW-1:0];
    end else begin
      res = r[TrigW-1:0];
    end
    return res;
  endfunction

  // Clamp a one-bit-wider value at the top of the trig range
  function automatic logic signed [TrigW-1:0] clamp_hi(logic signed [TrigW:0] v);
    logic signed [TrigW:0] hi;
    logic signed [TrigW-1:0] res;
    hi = (TrigW+1)'((64'd1 << TRIG_FRACTION_BITS) - 1);
    if (v > hi) begin
      res = hi[TrigW-1:0];
    end else begin
      res = v[TrigW-1:0];
    end
    return res;
  endfunction

  // Rounding and quadrant folding after the last CORDIC step
  function automatic trig_t trig_post(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                      logic [1:0] quad);
    logic signed [TrigW-1:0] cv;
    logic signed [TrigW-1:0] sv;
    logic signed [TrigW:0] cw;
    logic signed [TrigW:0] sw;
    trig_t res;
    cv = to_trig(x);
    sv = to_trig(y);
    case (quad)
      2'd0: begin
        cw = {cv[TrigW-1], cv};
        sw = {sv[TrigW-1], sv};
      end
      2'd1: begin
        cw = -{sv[TrigW-1], sv};
        sw = {cv[TrigW-1], cv};
      end
      2'd2: begin
        cw = -{cv[TrigW-1], cv};
        sw = -{sv[TrigW-1], sv};
      end
      default: begin
        cw = {sv[TrigW-1], sv};
        sw = -{cv[TrigW-1], cv};
      end
    endcase
    res.c = clamp_hi(cw);
    res.s = clamp_hi(sw);
    return res;
  endfunction

  // Link length times trig value, floored to whole pixels
  function automatic logic signed [DispW-1:0] link_disp(logic [LenW-1:0] len,
                                                        logic signed [TrigW-1:0] t);
    logic signed [ProdW-1:0] p;
    p = $signed({1'b0, len}) * t;
    return p[ProdW-1:TRIG_FRACTION_BITS];
  endfunction

  function automatic logic signed [CoordW-1:0] sat_coord(logic signed [PosW-1:0] v);
    logic signed [PosW-1:0] r;
    r = v;
    if (v < CoordMin) begin
      r = CoordMin;
    end else if (v > CoordMax) begin
      r = CoordMax;
    end
    return r[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/tlfk_cordic.sv]
// One rotation-mode CORDIC lane, one register stage per step, giving the
// first-quadrant cos and sin at 30 fraction bits plus the quadrant. Uses tlfk_pkg.
`default_nettype none

module tlfk_cordic
  import tlfk_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic [CordicSteps-1:0] ld_i,
  input  wire logic [ANGLE_BITS-1:0]  angle_i,
  output logic signed [CW-1:0]        x_o,
  output logic signed [CW-1:0]        y_o,
  output logic [1:0]                  quad_o
);

  logic [TurnW-1:0] turn;

  logic signed [CW-1:0] x_q    [CordicSteps];
  logic signed [CW-1:0] y_q    [CordicSteps];
  logic signed [ZW-1:0] z_q    [CordicSteps];
  logic [1:0]           quad_q [CordicSteps];

  assign turn = {angle_i, {(TurnW - ANGLE_BITS){1'b0}}};

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic [1:0]           q_in;

    if (i == 0) begin : g_first
      assign x_in = CordicGain;
      assign y_in = '0;
      assign z_in = {2'b00, turn[TurnW-3:0]};
      assign q_in = turn[TurnW-1:TurnW-2];
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign q_in = quad_q[i-1];
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (ld_i[i]) begin
        if (z_in[ZW-1]) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + AtanTurns[i];
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - AtanTurns[i];
        end
        quad_q[i] <= q_in;
      end
    end
  end

  assign x_o    = x_q[CordicSteps-1];
  assign y_o    = y_q[CordicSteps-1];
  assign quad_o = quad_q[CordicSteps-1];

endmodule

`default_nettype wire

[rtl/two_link_forward_kinematics.sv]
// Top level of the planar two-link arm forward kinematics block: config
// registers, stage valids, two CORDIC lanes and the position arithmetic.
// Depends on tlfk_pkg and tlfk_cordic.

// Each item carries a shoulder and an elbow angle (65536 counts per turn) and
// yields one result with the elbow and tip pixel positions, floored and
// saturated to -512..1535. The block takes one item per cycle unless stalled
// and passes it through one input stage, the 28 stages of the CORDIC lanes
// (shoulder angle and angle sum side by side), one stage of rounding and
// quadrant folding, one multiply stage and the output register.
// Each stage moves on as soon as the one after it is empty or moving, so a
// stall on the output side fills the pipe before the input stalls. Write the
// base position and link lengths only while no item is in flight.
`default_nettype none

module two_link_forward_kinematics
  import tlfk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire fk_in_t              in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output fk_out_t                  out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [BaseW-1:0] base_x_q;
  logic [BaseW-1:0] base_y_q;
  logic [LenW-1:0]  len1_q;
  logic [LenW-1:0]  len2_q;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] rdy;

  logic [ANGLE_BITS-1:0] a1_q;
  logic [ANGLE_BITS-1:0] sum_q;

  logic signed [CW-1:0] x1;
  logic signed [CW-1:0] y1;
  logic [1:0]           q1;
  logic signed [CW-1:0] x2;
  logic signed [CW-1:0] y2;
  logic [1:0]           q2;

  trig_t trig1_q;
  trig_t trig2_q;

  logic signed [PosW-1:0]  ex_q;
  logic signed [PosW-1:0]  ey_q;
  logic signed [DispW-1:0] d2x_q;
  logic signed [DispW-1:0] d2y_q;

  fk_out_t out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q <= BaseXReset;
      base_y_q <= BaseYReset;
      len1_q   <= FirstLReset;
      len2_q   <= SecondLReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBaseX:   base_x_q <= cfg_data_i[BaseW-1:0];
        CfgBaseY:   base_y_q <= cfg_data_i[BaseW-1:0];
        CfgFirstL:  len1_q   <= cfg_data_i[LenW-1:0];
        CfgSecondL: len2_q   <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its successor is loading
  always_comb begin
    rdy[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign valid_d = {valid_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // Input stage: the second link angle wraps modulo one turn
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a1_q  <= in_data_i.shoulder_angle;
      sum_q <= in_data_i.shoulder_angle + in_data_i.elbow_angle;
    end
  end

  tlfk_cordic u_cordic_1 (
    .clk_i,
    .ld_i    (rdy[CordicSteps:1]),
    .angle_i (a1_q),
    .x_o     (x1),
    .y_o     (y1),
    .quad_o  (q1)
  );

  tlfk_cordic u_cordic_2 (
    .clk_i,
    .ld_i    (rdy[CordicSteps:1]),
    .angle_i (sum_q),
    .x_o     (x2),
    .y_o     (y2),
    .quad_o  (q2)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[StTrig]) begin
      trig1_q <= trig_post(x1, y1, q1);
      trig2_q <= trig_post(x2, y2, q2);
    end
  end

  // Elbow on the floored, unsaturated first link; keep the second link offsets
  always_ff @(posedge clk_i) begin
    if (rdy[StMul]) begin
      ex_q  <= $signed({3'b000, base_x_q}) + PosW'(link_disp(len1_q, trig1_q.c));
      ey_q  <= $signed({3'b000, base_y_q}) + PosW'(link_disp(len1_q, trig1_q.s));
      d2x_q <= link_disp(len2_q, trig2_q.c);
      d2y_q <= link_disp(len2_q, trig2_q.s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StOut]) begin
      out_q.elbow_x <= sat_coord(ex_q);
      out_q.elbow_y <= sat_coord(ey_q);
      out_q.tip_x   <= sat_coord(ex_q + PosW'(d2x_q));
      out_q.tip_y   <= sat_coord(ey_q + PosW'(d2y_q));
    end
  end

  assign out_valid_o = valid_q[StOut];
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
